// ===== src/fcfs_task_scheduler_defines.svh =====
// Assertion macros used by the scheduler datapath
`ifndef FCFS_TASK_SCHEDULER_DEFINES_SVH
`define FCFS_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FTS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FTS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fts_pkg.sv =====
// Shared types and constants for the FCFS task scheduler
`timescale 1ns / 1ps

package fts_pkg;

    localparam int FTS_QUEUE_DEPTH = 16;

    localparam int TASK_W  = 8;
    localparam int BURST_W = 8;
    localparam int TIME_W  = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef enum logic [1:0] {
        EV_ARRIVED = 2'd0,
        EV_RUNNING = 2'd1,
        EV_EXIT    = 2'd2,
        EV_DROPPED = 2'd3
    } fts_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_TICK,
        ST_PROMOTE
    } fts_state_t;

    typedef struct packed {
        logic [TASK_W-1:0]  tid;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [TIME_W-1:0]  response;
        logic               started;
    } fts_entry_t;

    typedef struct packed {
        logic load;
        logic insert;
        logic drop;
        logic advance;
        logic run_tick;
        logic promote;
        logic pop;
    } fts_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic head_done;
        logic more;
    } fts_status_t;

endpackage

// ===== src/fts_ctrl.sv =====
// Sequencer for the FCFS task scheduler
`timescale 1ns / 1ps

module fts_ctrl
    import fts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        req_type,
    input  fts_status_t status,
    output fts_cmd_t    cmd,
    output logic        busy
);

    fts_state_t state_reg;
    fts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == REQ_TICK) ? ST_TICK : ST_ARRIVE;
                end
            end
            ST_ARRIVE:
            begin
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (!status.empty && status.head_done && status.more)
                begin
                    state_next = ST_PROMOTE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PROMOTE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_ARRIVE:
            begin
                cmd.insert = !status.full;
                cmd.drop   = status.full;
            end
            ST_TICK:
            begin
                cmd.advance  = 1'b1;
                cmd.run_tick = !status.empty && !status.head_done;
                cmd.pop      = !status.empty && status.head_done;
            end
            ST_PROMOTE:
            begin
                cmd.promote = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/fts_datapath.sv =====
// Ready-queue cell chain, time base and result registers
`timescale 1ns / 1ps
`include "fcfs_task_scheduler_defines.svh"

module fts_datapath
    import fts_pkg::*;
#(
    parameter int QUEUE_DEPTH = FTS_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  fts_cmd_t           cmd,
    input  logic [TASK_W-1:0]  task_id,
    input  logic [BURST_W-1:0] burst_len,
    output fts_status_t        status,
    output logic               result_strobe,
    output logic [1:0]         event_kind,
    output logic [TIME_W-1:0]  event_time,
    output logic [TASK_W-1:0]  event_task,
    output logic [TIME_W-1:0]  arrival_stamp,
    output logic [BURST_W-1:0] initial_burst,
    output logic [TIME_W-1:0]  turnaround,
    output logic [TIME_W-1:0]  wait_ticks,
    output logic [TIME_W-1:0]  response_ticks,
    output logic               last_of_run
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  time_next;
    logic [TIME_W-1:0]  stamp_reg;
    logic [TIME_W-1:0]  stamp_next;
    logic [TASK_W-1:0]  id_reg;
    logic [BURST_W-1:0] burst_reg;

    fts_entry_t entry_reg  [QUEUE_DEPTH];
    fts_entry_t entry_next [QUEUE_DEPTH];
    fts_entry_t prev_entry [QUEUE_DEPTH];
    fts_entry_t succ_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] le;
    logic [QUEUE_DEPTH-1:0] prev_le;

    fts_entry_t         new_entry;
    fts_entry_t         run_entry;
    logic [TIME_W-1:0]  run_time;
    logic [TIME_W-1:0]  since;
    logic [TIME_W-1:0]  wait_val;
    logic [TIME_W-1:0]  resp_val;

    logic               strobe_reg;
    fts_event_t         kind_reg;
    logic [TIME_W-1:0]  ev_time_reg;
    logic [TASK_W-1:0]  ev_task_reg;
    logic [TIME_W-1:0]  arr_reg;
    logic [BURST_W-1:0] ib_reg;
    logic [TIME_W-1:0]  tat_reg;
    logic [TIME_W-1:0]  wait_reg;
    logic [TIME_W-1:0]  resp_reg;
    logic               last_reg;

    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg == CW'(QUEUE_DEPTH));
    assign status.head_done = (entry_reg[0].remaining == '0);
    assign status.more      = (count_reg > CW'(1));

    always_comb
    begin
        new_entry           = '0;
        new_entry.tid       = id_reg;
        new_entry.arrival   = stamp_reg;
        new_entry.burst     = burst_reg;
        new_entry.remaining = burst_reg;
    end

    assign run_time = cmd.promote ? time_reg : stamp_reg;
    assign since    = (run_time >= entry_reg[0].arrival) ?
                      run_time - entry_reg[0].arrival : '0;
    assign wait_val = (since > TIME_W'(entry_reg[0].burst)) ?
                      since - TIME_W'(entry_reg[0].burst) : '0;
    assign resp_val = entry_reg[0].started ? entry_reg[0].response : since;

    always_comb
    begin
        run_entry = entry_reg[0];
        if (entry_reg[0].remaining != '0)
        begin
            run_entry.remaining = entry_reg[0].remaining - 1'b1;
        end
        if (!entry_reg[0].started)
        begin
            run_entry.response = since;
            run_entry.started  = 1'b1;
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign le[i] = (CW'(i) < count_reg) &&
                       ((entry_reg[i].arrival < stamp_reg) ||
                        ((entry_reg[i].arrival == stamp_reg) && (entry_reg[i].tid <= id_reg)));

        if (i == 0)
        begin : g_first
            assign prev_le[i]    = 1'b1;
            assign prev_entry[i] = new_entry;
        end
        else
        begin : g_rest
            assign prev_le[i]    = le[i-1];
            assign prev_entry[i] = entry_reg[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign succ_entry[i] = entry_reg[i];
        end
        else
        begin : g_inner
            assign succ_entry[i] = entry_reg[i+1];
        end

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (cmd.insert)
            begin
                if (!le[i])
                begin
                    entry_next[i] = prev_le[i] ? new_entry : prev_entry[i];
                end
            end
            else if (cmd.pop)
            begin
                entry_next[i] = succ_entry[i];
            end
            else if ((cmd.run_tick || cmd.promote) && (i == 0))
            begin
                entry_next[i] = run_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (cmd.load)
        begin
            id_reg    <= task_id;
            burst_reg <= burst_len;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        time_next  = time_reg;
        stamp_next = stamp_reg;
        if (cmd.advance)
        begin
            time_next  = stamp_reg;
            stamp_next = (stamp_reg == TIME_MAX) ? stamp_reg : stamp_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            time_reg   <= '0;
            stamp_reg  <= TIME_W'(1);
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            time_reg   <= time_next;
            stamp_reg  <= stamp_next;
            strobe_reg <= cmd.insert || cmd.drop || cmd.run_tick || cmd.promote || cmd.pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert || cmd.drop || cmd.run_tick || cmd.promote || cmd.pop)
        begin
            arr_reg  <= '0;
            ib_reg   <= '0;
            tat_reg  <= '0;
            wait_reg <= '0;
            resp_reg <= '0;
            last_reg <= 1'b1;
            if (cmd.insert || cmd.drop)
            begin
                kind_reg    <= cmd.drop ? EV_DROPPED : EV_ARRIVED;
                ev_time_reg <= stamp_reg;
                ev_task_reg <= id_reg;
            end
            else if (cmd.pop)
            begin
                kind_reg    <= EV_EXIT;
                ev_time_reg <= stamp_reg;
                ev_task_reg <= entry_reg[0].tid;
                arr_reg     <= entry_reg[0].arrival;
                ib_reg      <= entry_reg[0].burst;
                tat_reg     <= since;
                wait_reg    <= wait_val;
                resp_reg    <= resp_val;
                last_reg    <= !status.more;
            end
            else
            begin
                kind_reg    <= EV_RUNNING;
                ev_time_reg <= run_time;
                ev_task_reg <= entry_reg[0].tid;
            end
        end
    end

    assign result_strobe  = strobe_reg;
    assign event_kind     = kind_reg;
    assign event_time     = ev_time_reg;
    assign event_task     = ev_task_reg;
    assign arrival_stamp  = arr_reg;
    assign initial_burst  = ib_reg;
    assign turnaround     = tat_reg;
    assign wait_ticks     = wait_reg;
    assign response_ticks = resp_reg;
    assign last_of_run    = last_reg;

    `FTS_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH), "queue count past depth")
    `FTS_ASSERT_IMP(a_insert_room, cmd.insert, !status.full, "insert into a full queue")
    `FTS_ASSERT_NXT(a_pop_count, cmd.pop, count_reg == $past(count_reg) - 1'b1, "pop lost count")
    `FTS_ASSERT_NXT(a_time_mono, cmd.advance, time_reg >= $past(time_reg), "time went backward")

endmodule

// ===== src/fcfs_task_scheduler.sv =====
// Top level of the FCFS task scheduler
`timescale 1ns / 1ps

// A beat is taken when start is high and busy is low. An arrival's work cycle
// inserts into a chain of QUEUE_DEPTH cells, all compared in parallel against
// the new key, or drops the task if full. A tick's work cycle advances time and
// runs the head, or pops it and then promotes the next task if one waits.
// Each result sits on the ports for exactly one cycle with result_strobe high,
// in the cycle after the work cycle that made it; the receiver cannot stall, so
// capture every strobed beat. When an exit promotes the next task, that task's
// running report follows the exit, with last_of_run high.
module fcfs_task_scheduler
    import fts_pkg::*;
#(
    parameter int QUEUE_DEPTH = FTS_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic [TASK_W-1:0]  task_id,
    input  logic [BURST_W-1:0] burst_len,
    output logic               result_strobe,
    output logic [1:0]         event_kind,
    output logic [TIME_W-1:0]  event_time,
    output logic [TASK_W-1:0]  event_task,
    output logic [TIME_W-1:0]  arrival_stamp,
    output logic [BURST_W-1:0] initial_burst,
    output logic [TIME_W-1:0]  turnaround,
    output logic [TIME_W-1:0]  wait_ticks,
    output logic [TIME_W-1:0]  response_ticks,
    output logic               last_of_run
);

    fts_cmd_t    cmd;
    fts_status_t status;

    fts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    fts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .task_id        (task_id),
        .burst_len      (burst_len),
        .status         (status),
        .result_strobe  (result_strobe),
        .event_kind     (event_kind),
        .event_time     (event_time),
        .event_task     (event_task),
        .arrival_stamp  (arrival_stamp),
        .initial_burst  (initial_burst),
        .turnaround     (turnaround),
        .wait_ticks     (wait_ticks),
        .response_ticks (response_ticks),
        .last_of_run    (last_of_run)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for fcfs_task_scheduler: tracks the ready queue and checks events
`timescale 1ns / 1ps

module tb_top;
    import fts_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        fts_event_t          kind;
        logic [TIME_W-1:0]   ev_time;
        logic [TASK_W-1:0]   ev_task;
        logic [TIME_W-1:0]   arrival;
        logic [BURST_W-1:0]  burst;
        logic [TIME_W-1:0]   tat;
        logic [TIME_W-1:0]   wait_t;
        logic [TIME_W-1:0]   resp;
        logic                last;
    } sched_event_t;

    class sched_scoreboard;
        fts_entry_t        ready_tasks[$];
        sched_event_t      due_events[$];
        logic [TIME_W-1:0] now_tick = '0;
        bit                failed = 1'b0;

        function int unsigned outstanding();
            return due_events.size();
        endfunction

        function logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] stamp);
            return (now_tick >= stamp) ? now_tick - stamp : '0;
        endfunction

        function void add_due(fts_event_t kind, logic [TIME_W-1:0] at,
                              logic [TASK_W-1:0] tid, logic [TIME_W-1:0] arr,
                              logic [BURST_W-1:0] ib, logic [TIME_W-1:0] tat,
                              logic [TIME_W-1:0] wt, logic [TIME_W-1:0] rsp,
                              logic last);
            sched_event_t ev;
            ev.kind    = kind;
            ev.ev_time = at;
            ev.ev_task = tid;
            ev.arrival = arr;
            ev.burst   = ib;
            ev.tat     = tat;
            ev.wait_t  = wt;
            ev.resp    = rsp;
            ev.last    = last;
            due_events.push_back(ev);
        endfunction

        function void run_head();
            fts_entry_t h;
            h = ready_tasks[0];
            if (h.remaining != 0)
                h.remaining = h.remaining - 1'b1;
            if (!h.started)
            begin
                h.response = elapsed(h.arrival);
                h.started  = 1'b1;
            end
            ready_tasks[0] = h;
            add_due(EV_RUNNING, now_tick, h.tid, '0, '0, '0, '0, '0, 1'b1);
        endfunction

        function void note_request(logic rt, logic [TASK_W-1:0] id,
                                   logic [BURST_W-1:0] bl);
            logic [TIME_W-1:0] stamp;
            logic [TIME_W-1:0] tat;
            logic [TIME_W-1:0] wt;
            logic [TIME_W-1:0] rsp;
            fts_entry_t        e;
            int                p;
            stamp = (now_tick != TIME_MAX) ? now_tick + 1'b1 : TIME_MAX;
            if (rt == REQ_ARRIVAL)
            begin
                if (ready_tasks.size() >= FTS_QUEUE_DEPTH)
                begin
                    add_due(EV_DROPPED, stamp, id, '0, '0, '0, '0, '0, 1'b1);
                    return;
                end
                p = 0;
                while (p < ready_tasks.size() &&
                       (ready_tasks[p].arrival < stamp ||
                        (ready_tasks[p].arrival == stamp && ready_tasks[p].tid <= id)))
                    p++;
                e.tid       = id;
                e.arrival   = stamp;
                e.burst     = bl;
                e.remaining = bl;
                e.response  = '0;
                e.started   = 1'b0;
                ready_tasks.insert(p, e);
                add_due(EV_ARRIVED, stamp, id, '0, '0, '0, '0, '0, 1'b1);
                return;
            end
            now_tick = stamp;
            if (ready_tasks.size() == 0)
                return;
            e = ready_tasks[0];
            if (e.remaining != 0)
            begin
                run_head();
                return;
            end
            tat = elapsed(e.arrival);
            wt  = (tat > e.burst) ? tat - e.burst : '0;
            rsp = e.started ? e.response : tat;
            add_due(EV_EXIT, now_tick, e.tid, e.arrival, e.burst, tat, wt, rsp,
                    (ready_tasks.size() > 1) ? 1'b0 : 1'b1);
            void'(ready_tasks.pop_front());
            if (ready_tasks.size() != 0)
                run_head();
        endfunction

        function void check_field(string name, logic [TIME_W-1:0] want,
                                  logic [TIME_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                failed = 1'b1;
            end
        endfunction

        function void check_event(sched_event_t got);
            sched_event_t want;
            if (due_events.size() == 0)
            begin
                $display("%0t: event expected none actual kind %0d task %0d",
                         $time, got.kind, got.ev_task);
                failed = 1'b1;
                return;
            end
            want = due_events.pop_front();
            check_field("event_kind", TIME_W'(want.kind), TIME_W'(got.kind));
            check_field("event_time", want.ev_time, got.ev_time);
            check_field("event_task", TIME_W'(want.ev_task), TIME_W'(got.ev_task));
            check_field("arrival_stamp", want.arrival, got.arrival);
            check_field("initial_burst", TIME_W'(want.burst), TIME_W'(got.burst));
            check_field("turnaround", want.tat, got.tat);
            check_field("wait_ticks", want.wait_t, got.wait_t);
            check_field("response_ticks", want.resp, got.resp);
            check_field("last_of_run", TIME_W'(want.last), TIME_W'(got.last));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               req_type = REQ_ARRIVAL;
    logic [TASK_W-1:0]  task_id = '0;
    logic [BURST_W-1:0] burst_len = '0;
    logic               result_strobe;
    logic [1:0]         event_kind;
    logic [TIME_W-1:0]  event_time;
    logic [TASK_W-1:0]  event_task;
    logic [TIME_W-1:0]  arrival_stamp;
    logic [BURST_W-1:0] initial_burst;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  wait_ticks;
    logic [TIME_W-1:0]  response_ticks;
    logic               last_of_run;

    sched_scoreboard sb = new();
    int unsigned     beats_sent = 0;
    int unsigned     cycle_count = 0;

    fcfs_task_scheduler DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .task_id        (task_id),
        .burst_len      (burst_len),
        .result_strobe  (result_strobe),
        .event_kind     (event_kind),
        .event_time     (event_time),
        .event_task     (event_task),
        .arrival_stamp  (arrival_stamp),
        .initial_burst  (initial_burst),
        .turnaround     (turnaround),
        .wait_ticks     (wait_ticks),
        .response_ticks (response_ticks),
        .last_of_run    (last_of_run)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("fcfs_task_scheduler: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sched_event_t got;
        if (rst_n && result_strobe)
        begin
            got.kind    = fts_event_t'(event_kind);
            got.ev_time = event_time;
            got.ev_task = event_task;
            got.arrival = arrival_stamp;
            got.burst   = initial_burst;
            got.tat     = turnaround;
            got.wait_t  = wait_ticks;
            got.resp    = response_ticks;
            got.last    = last_of_run;
            sb.check_event(got);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // hold the beat until taken, then idle for the gap
    task automatic send_beat(input logic rt, input logic [TASK_W-1:0] id,
                             input logic [BURST_W-1:0] bl, input int gap);
        start     <= 1'b1;
        req_type  <= rt;
        task_id   <= id;
        burst_len <= bl;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(rt, id, bl);
        beats_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    task automatic run_random(input int unsigned quota);
        int unsigned        target;
        int                 kind;
        int                 n;
        bit                 calm;
        logic [TASK_W-1:0]  id;
        logic [BURST_W-1:0] bl;
        target = beats_sent + quota;
        while (beats_sent < target)
        begin
            kind = $urandom_range(0, 19);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            if (kind <= 5)
                n = $urandom_range(1, 3);
            else if (kind == 6)
                n = $urandom_range(10, 20);
            else
                n = $urandom_range(1, 20);
            repeat (n)
            begin
                id = TASK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                          : $urandom_range(0, 255));
                bl = BURST_W'(($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
                                                            : $urandom_range(0, 3));
                send_beat((kind <= 6) ? REQ_ARRIVAL : REQ_TICK, id, bl,
                          calm ? 0 : pick_gap());
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(REQ_TICK, 8'h00, 8'h00, pick_gap());
        send_beat(REQ_ARRIVAL, 8'hFF, 8'h00, pick_gap());
        send_beat(REQ_ARRIVAL, 8'h00, 8'h02, pick_gap());
        send_beat(REQ_ARRIVAL, 8'h00, 8'h01, pick_gap());
        repeat (5) send_beat(REQ_TICK, 8'hFF, 8'hFF, pick_gap());
        send_beat(REQ_ARRIVAL, 8'hA5, 8'h00, pick_gap());
        send_beat(REQ_TICK, 8'h00, 8'h00, pick_gap());
        send_beat(REQ_ARRIVAL, 8'h5A, 8'hFF, pick_gap());
        send_beat(REQ_ARRIVAL, 8'h01, 8'h80, pick_gap());
        send_beat(REQ_TICK, 8'h00, 8'h00, pick_gap());
        wait_drained();

        run_random(420);
        wait_drained();

        run_random(230);
        wait_drained();
        repeat (8) @(posedge clk);

        if (!sb.failed && sb.outstanding() == 0)
            $display("fcfs_task_scheduler: match");
        else
            $display("fcfs_task_scheduler: mismatch");
        $finish;
    end

endmodule
